// ----- design/gbn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

  // Field widths fixed by the packet format
  localparam int OP_W          = 2;
  localparam int MODE_W        = 8;
  localparam int FILE_BYTES_W  = 32;
  localparam int SEQ_IN_W      = 32;
  localparam int PAYLOAD_W     = 64;
  localparam int ACK_W         = 30;
  localparam int STATUS_W      = 2;

  // 16-byte blocks
  localparam int BLK_LOG2      = 4;

  // Default number of file size bits honoured
  localparam int SIZE_BITS_DEF = 32;

  localparam logic [MODE_W-1:0] LOCAL_MODE_RST = 8'd1;

  // Packet types
  localparam logic [OP_W-1:0] OP_INIT = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_RUN  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd2;

  localparam logic signed [ACK_W-1:0] ACK_FAIL = -30'sd1;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_RUN,
    PH_FAIL,
    PH_DONE
  } gbn_phase_t;

  typedef struct packed {
    logic        [OP_W-1:0]         op;
    logic        [MODE_W-1:0]       peer_mode;
    logic        [FILE_BYTES_W-1:0] file_bytes;
    logic signed [SEQ_IN_W-1:0]     seq_in;
    logic        [PAYLOAD_W-1:0]    payload_low;
    logic        [PAYLOAD_W-1:0]    payload_high;
  } gbn_item_t;

  typedef struct packed {
    logic signed [ACK_W-1:0]     ack_number;
    logic                        deliver;
    logic        [PAYLOAD_W-1:0] out_low;
    logic        [PAYLOAD_W-1:0] out_high;
    logic        [STATUS_W-1:0]  status;
  } gbn_result_t;

endpackage

`default_nettype wire

// ----- design/gbn_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input register: holds one packet until the core takes it.
module gbn_in_stage (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_stall,
  input  wire                gbn_pkg::gbn_item_t in_item,
  input  wire                logic take,
  output logic               item_vld,
  output gbn_pkg::gbn_item_t item
);

  logic               vld_r, vld_nxt;
  gbn_pkg::gbn_item_t item_r;
  logic               load;

  assign in_stall = vld_r & ~take;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

// ----- design/gbn_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Receiver state machine: phase, expected and last block numbers.
module gbn_core #(
  parameter int SIZE_BITS = gbn_pkg::SIZE_BITS_DEF
) (
  input  wire                  logic clk,
  input  wire                  logic rst_n,
  input  wire                  logic take,
  input  wire                  gbn_pkg::gbn_item_t item,
  input  wire                  logic [gbn_pkg::MODE_W-1:0] local_mode,
  output logic                 res_vld,
  output gbn_pkg::gbn_result_t res
);

  localparam int EFF_W = (SIZE_BITS < gbn_pkg::FILE_BYTES_W) ? SIZE_BITS
                                                             : gbn_pkg::FILE_BYTES_W;
  // quotient bits plus one for the round-up carry
  localparam int SEQ_W = EFF_W - gbn_pkg::BLK_LOG2 + 1;

  gbn_pkg::gbn_phase_t phase_r, phase_nxt;
  logic [SEQ_W-1:0]    exp_r, exp_nxt;
  logic [SEQ_W-1:0]    last_r, last_nxt;
  logic [SEQ_W-1:0]    exp_inc;
  logic [SEQ_W-1:0]    last_calc;
  logic [EFF_W-1:0]    bytes_eff;
  logic                seq_match;

  assign exp_inc   = exp_r + 1'b1;
  assign bytes_eff = item.file_bytes[EFF_W-1:0];
  assign last_calc = {1'b0, bytes_eff[EFF_W-1:gbn_pkg::BLK_LOG2]}
                   + {{(SEQ_W-1){1'b0}}, |bytes_eff[gbn_pkg::BLK_LOG2-1:0]};
  // negative or out-of-range numbers never match
  assign seq_match = (item.seq_in[gbn_pkg::SEQ_IN_W-1:SEQ_W] == '0)
                   && (item.seq_in[SEQ_W-1:0] == exp_r);

  always_comb begin
    phase_nxt = phase_r;
    exp_nxt   = exp_r;
    last_nxt  = last_r;
    res_vld   = 1'b0;
    res       = '0;
    if (take) begin
      unique case (phase_r)
        gbn_pkg::PH_WAIT: begin
          if (item.op == gbn_pkg::OP_INIT) begin
            res_vld = 1'b1;
            if (item.peer_mode != local_mode) begin
              phase_nxt      = gbn_pkg::PH_FAIL;
              res.ack_number = gbn_pkg::ACK_FAIL;
              res.status     = gbn_pkg::ST_FAIL;
            end else begin
              phase_nxt      = gbn_pkg::PH_RUN;
              last_nxt       = last_calc;
              exp_nxt        = exp_inc;
              res.ack_number = $signed({{(gbn_pkg::ACK_W-SEQ_W){1'b0}}, exp_r});
              res.status     = gbn_pkg::ST_RUN;
            end
          end
        end
        gbn_pkg::PH_RUN: begin
          if (item.op == gbn_pkg::OP_DATA) begin
            res_vld = 1'b1;
            if (seq_match) begin
              exp_nxt      = exp_inc;
              res.deliver  = 1'b1;
              res.out_low  = item.payload_low;
              res.out_high = item.payload_high;
            end
            res.ack_number = $signed({{(gbn_pkg::ACK_W-SEQ_W){1'b0}}, exp_nxt});
            if (exp_nxt > last_r) begin
              res.status = gbn_pkg::ST_DONE;
              phase_nxt  = gbn_pkg::PH_DONE;
            end else begin
              res.status = gbn_pkg::ST_RUN;
            end
          end
        end
        gbn_pkg::PH_FAIL, gbn_pkg::PH_DONE: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= gbn_pkg::PH_WAIT;
      exp_r   <= '0;
      last_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      exp_r   <= exp_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/gbn_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Result register: holds one ack until the downstream side takes it.
module gbn_out_stage (
  input  wire                  logic clk,
  input  wire                  logic rst_n,
  input  wire                  logic res_vld,
  input  wire                  gbn_pkg::gbn_result_t res,
  input  wire                  logic out_stall,
  output logic                 out_valid,
  output logic                 free,
  output gbn_pkg::gbn_result_t out_res
);

  logic                 vld_r, vld_nxt;
  gbn_pkg::gbn_result_t res_r;

  assign free = ~vld_r | ~out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (res_vld) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ----- design/go_back_n_receiver_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Go-Back-N receiver, one packet per transaction.
// Input channel (in_valid / in_stall): op, peer mode, file size, sequence
//   number and a 16-byte payload. Op 1 is init, op 3 is data, others ignored.
// Output channel (out_valid / out_stall): one ack per init or data packet that
//   the current phase honours: ack number, deliver flag with the in-order
//   payload (zero otherwise) and status (running, mode mismatch, complete).
// Config channel (cfg_valid / cfg_ready): receiver mode, always ready; write
//   it only while no packet is in flight. Reset value 1.
// A packet accepted into the input register passes the state machine into
//   the result register, which shows its ack at out_valid. Throughput: one
//   packet per cycle while no held ack is stalled, set by that single pass.
// Packets that give no ack are still consumed at one per cycle unless stalled.
// Reset (rst_n low, synchronous): phase back to waiting for init, expected
//   and last block numbers zero, both registers empty, mode back to 1.
// When out_stall holds a pending ack, one more packet waits in the input
//   register and in_stall rises until the ack is taken.
module go_back_n_receiver_unit #(
  parameter int SIZE_BITS = gbn_pkg::SIZE_BITS_DEF
) (
  input  wire  logic                                clk,
  input  wire  logic                                rst_n,
  input  wire  logic                                in_valid,
  output logic                                      in_stall,
  input  wire  logic        [gbn_pkg::OP_W-1:0]         in_op,
  input  wire  logic        [gbn_pkg::MODE_W-1:0]       in_peer_mode,
  input  wire  logic        [gbn_pkg::FILE_BYTES_W-1:0] in_file_bytes,
  input  wire  logic signed [gbn_pkg::SEQ_IN_W-1:0]     in_seq_in,
  input  wire  logic        [gbn_pkg::PAYLOAD_W-1:0]    in_payload_low,
  input  wire  logic        [gbn_pkg::PAYLOAD_W-1:0]    in_payload_high,
  output logic                                      out_valid,
  input  wire  logic                                out_stall,
  output logic signed [gbn_pkg::ACK_W-1:0]          out_ack_number,
  output logic                                      out_deliver,
  output logic        [gbn_pkg::PAYLOAD_W-1:0]      out_low,
  output logic        [gbn_pkg::PAYLOAD_W-1:0]      out_high,
  output logic        [gbn_pkg::STATUS_W-1:0]       out_status,
  input  wire  logic                                cfg_valid,
  output logic                                      cfg_ready,
  input  wire  logic        [gbn_pkg::MODE_W-1:0]   cfg_local_mode
);

  gbn_pkg::gbn_item_t   in_item;
  gbn_pkg::gbn_item_t   item;
  gbn_pkg::gbn_result_t res;
  gbn_pkg::gbn_result_t out_res;
  logic                 item_vld;
  logic                 out_free;
  logic                 take;
  logic                 res_vld;
  logic [gbn_pkg::MODE_W-1:0] local_mode_r;

  assign in_item.op           = in_op;
  assign in_item.peer_mode    = in_peer_mode;
  assign in_item.file_bytes   = in_file_bytes;
  assign in_item.seq_in       = in_seq_in;
  assign in_item.payload_low  = in_payload_low;
  assign in_item.payload_high = in_payload_high;

  // core works on the held packet whenever the result register has room
  assign take = item_vld & out_free;

  // mode register, writable at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mode_r <= gbn_pkg::LOCAL_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      local_mode_r <= cfg_local_mode;
    end
  end

  gbn_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  gbn_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .item       (item),
    .local_mode (local_mode_r),
    .res_vld    (res_vld),
    .res        (res)
  );

  gbn_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (out_free),
    .out_res   (out_res)
  );

  assign out_ack_number = out_res.ack_number;
  assign out_deliver    = out_res.deliver;
  assign out_low        = out_res.out_low;
  assign out_high       = out_res.out_high;
  assign out_status     = out_res.status;

endmodule

`default_nettype wire

// ----- design/gbn_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gbn_checker (
  input wire logic                                   clk,
  input wire logic                                   rst_n,
  input wire logic                                   in_stall,
  input wire logic                                   out_valid,
  input wire logic                                   out_stall,
  input wire logic signed [gbn_pkg::ACK_W-1:0]       out_ack_number,
  input wire logic                                   out_deliver,
  input wire logic        [gbn_pkg::PAYLOAD_W-1:0]   out_low,
  input wire logic        [gbn_pkg::PAYLOAD_W-1:0]   out_high,
  input wire logic        [gbn_pkg::STATUS_W-1:0]    out_status
);

  // both registers empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("registers not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ack_number)
      && $stable(out_status) && $stable(out_deliver))
    else $error("stalled ack changed");

  // payload is zero unless delivered
  a_no_stray_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_deliver |-> out_low == '0 && out_high == '0)
    else $error("payload on an ack without delivery");

  // mismatch ack is -1 and never delivers
  a_fail_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == gbn_pkg::ST_FAIL
      |-> out_ack_number == gbn_pkg::ACK_FAIL && !out_deliver)
    else $error("bad mismatch ack");

  // a delivered block always acks a positive number
  a_deliver_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deliver |-> out_ack_number > 0
      && out_status != gbn_pkg::ST_FAIL)
    else $error("delivery with bad ack");

endmodule

bind go_back_n_receiver_unit gbn_checker u_gbn_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ack_number (out_ack_number),
  .out_deliver    (out_deliver),
  .out_low        (out_low),
  .out_high       (out_high),
  .out_status     (out_status)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Go-Back-N receiver regression. One receive session per run: the block only
// leaves its terminal phases through reset, and reset is applied once.
module testbench;
  import gbn_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;      // ack comes from the result register after accept
  localparam int SIZE_BITS      = SIZE_BITS_DEF;
  localparam longint unsigned BLOCK_REM = (64'd1 << BLK_LOG2) - 64'd1;

  // packet types the receiver never answers
  localparam logic [OP_W-1:0] OP_SPARE_LO = 2'd0;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 2'd2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic        [OP_W-1:0]         in_op           = '0;
  logic        [MODE_W-1:0]       in_peer_mode    = '0;
  logic        [FILE_BYTES_W-1:0] in_file_bytes   = '0;
  logic signed [SEQ_IN_W-1:0]     in_seq_in       = '0;
  logic        [PAYLOAD_W-1:0]    in_payload_low  = '0;
  logic        [PAYLOAD_W-1:0]    in_payload_high = '0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [ACK_W-1:0]     out_ack_number;
  logic                        out_deliver;
  logic        [PAYLOAD_W-1:0] out_low;
  logic        [PAYLOAD_W-1:0] out_high;
  logic        [STATUS_W-1:0]  out_status;

  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  logic [MODE_W-1:0] cfg_local_mode = '0;

  // Shadow copy of the receiver: phase, block counters and mode register
  gbn_phase_t      rx_phase    = PH_WAIT;
  longint unsigned rx_expected = 0;
  longint unsigned rx_last     = 0;
  logic [MODE_W-1:0] rx_mode   = LOCAL_MODE_RST;

  gbn_result_t acks_due[$];    // acks owed by the block, oldest first
  gbn_result_t ack_want;
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  bit          in_calm      = 1'b0;

  go_back_n_receiver_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_peer_mode   (in_peer_mode),
    .in_file_bytes  (in_file_bytes),
    .in_seq_in      (in_seq_in),
    .in_payload_low (in_payload_low),
    .in_payload_high(in_payload_high),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ack_number (out_ack_number),
    .out_deliver    (out_deliver),
    .out_low        (out_low),
    .out_high       (out_high),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_local_mode (cfg_local_mode)
  );

  always #5 clk = ~clk;

  // Works out the ack, if any, for one accepted packet and moves the shadow
  // state on. Returns 1 when an ack is owed.
  function automatic bit advance_receiver(input gbn_item_t pkt, output gbn_result_t ack);
    longint unsigned bytes;
    bit in_order;
    ack = '0;
    advance_receiver = 1'b0;
    case (rx_phase)
      PH_WAIT: begin
        if (pkt.op == OP_INIT) begin
          advance_receiver = 1'b1;
          if (pkt.peer_mode != rx_mode) begin
            // mode mismatch: negative ack, receiver dead until reset
            ack.ack_number = ACK_FAIL;
            ack.status     = ST_FAIL;
            rx_phase       = PH_FAIL;
          end else begin
            bytes = 64'(pkt.file_bytes) & ((64'd1 << SIZE_BITS) - 64'd1);
            // size rounded up to whole blocks
            rx_last = (bytes >> BLK_LOG2) + ((bytes & BLOCK_REM) != 0);
            ack.ack_number = rx_expected[ACK_W-1:0];
            ack.status     = ST_RUN;
            rx_expected    = rx_expected + 1;
            rx_phase       = PH_RUN;
          end
        end
      end
      PH_RUN: begin
        if (pkt.op == OP_DATA) begin
          advance_receiver = 1'b1;
          // a negative number never matches, whatever its low bits
          in_order = !pkt.seq_in[SEQ_IN_W-1] && ({32'd0, pkt.seq_in} == rx_expected);
          if (in_order) begin
            rx_expected  = rx_expected + 1;
            ack.deliver  = 1'b1;
            ack.out_low  = pkt.payload_low;
            ack.out_high = pkt.payload_high;
          end
          ack.ack_number = rx_expected[ACK_W-1:0];
          ack.status     = (rx_expected > rx_last) ? ST_DONE : ST_RUN;
          if (ack.status == ST_DONE) rx_phase = PH_DONE;
        end
      end
      default: ;  // failed or complete: everything is dropped silently
    endcase
  endfunction

  function automatic gbn_item_t random_packet();
    gbn_item_t pkt;
    pkt.op           = OP_W'($urandom_range(0, 3));
    pkt.peer_mode    = MODE_W'($urandom);
    pkt.file_bytes   = $urandom;
    pkt.seq_in       = $urandom;
    pkt.payload_low  = {$urandom, $urandom};
    pkt.payload_high = {$urandom, $urandom};
    return pkt;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Input side: random gap (or a calm stretch of back-to-back transactions),
  // then hold the packet until it is taken. Valid is only lowered when a gap
  // follows, so it never drops and rises within one time step.
  task automatic send_packet(input gbn_item_t pkt);
    int gap;
    gbn_result_t ack;
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= pkt.op;
    in_peer_mode    <= pkt.peer_mode;
    in_file_bytes   <= pkt.file_bytes;
    in_seq_in       <= pkt.seq_in;
    in_payload_low  <= pkt.payload_low;
    in_payload_high <= pkt.payload_high;
    do @(posedge clk); while (in_stall);
    if (advance_receiver(pkt, ack)) acks_due.push_back(ack);
  endtask

  // Idle the input, let owed acks drain, then allow for a silent packet still
  // working its way through.
  task automatic drain();
    in_valid <= 1'b0;
    while (acks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] mode);
    cfg_valid      <= 1'b1;
    cfg_local_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    rx_mode = mode;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Both extremes first; the last, random value is the one the session uses.
  task automatic test_mode_register();
    write_mode(8'hFF);
    write_mode(8'h00);
    write_mode(MODE_W'($urandom));
  endtask

  // Nothing is answered while waiting for init, data included.
  task automatic test_ignored_before_init();
    gbn_item_t pkt;
    pkt = '1;
    pkt.op = OP_SPARE_HI;
    send_packet(pkt);
    pkt = '0;
    pkt.op = OP_SPARE_LO;
    send_packet(pkt);
    pkt = '1;
    pkt.op = OP_DATA;
    send_packet(pkt);
    pkt = '0;
    pkt.op = OP_DATA;                 // sequence 0 still dropped before init
    send_packet(pkt);
    pkt = random_packet();
    pkt.op = OP_DATA;
    send_packet(pkt);
  endtask

  // Matching init opens the session; later inits, matching or not, are dropped.
  task automatic test_init();
    gbn_item_t pkt;
    int blocks;
    blocks = $urandom_range(790, 830);
    pkt = random_packet();
    pkt.op         = OP_INIT;
    pkt.peer_mode  = rx_mode;
    pkt.file_bytes = 32'((blocks - 1) * 16 + $urandom_range(1, 16));
    send_packet(pkt);
    pkt = '1;
    pkt.op        = OP_INIT;
    pkt.peer_mode = ~rx_mode;
    send_packet(pkt);
    pkt.peer_mode = rx_mode;
    send_packet(pkt);
  endtask

  // In-order, duplicate, stale, ahead and negative sequence numbers.
  task automatic test_data_cases();
    gbn_item_t pkt;
    pkt = '1;
    pkt.op     = OP_DATA;
    pkt.seq_in = rx_expected[31:0];
    send_packet(pkt);                 // in order, payload all ones
    send_packet(pkt);                 // duplicate
    pkt.seq_in = '0;
    send_packet(pkt);
    pkt.seq_in = {1'b1, rx_expected[30:0]};   // negative, low bits match
    send_packet(pkt);
    pkt.seq_in = 32'sh7FFF_FFFF;
    send_packet(pkt);
    pkt.seq_in = 32'sh8000_0000;
    send_packet(pkt);
    pkt.seq_in = -32'sd1;
    send_packet(pkt);
    pkt.seq_in = 32'(rx_expected + 5);
    send_packet(pkt);
    pkt = '0;
    pkt.op     = OP_DATA;
    pkt.seq_in = rx_expected[31:0];
    send_packet(pkt);                 // in order, payload all zeros
    pkt = '1;
    pkt.op = OP_SPARE_LO;
    send_packet(pkt);
    pkt.op = OP_SPARE_HI;
    send_packet(pkt);
  endtask

  // Mostly in-order data with random payloads, mixed with retransmissions,
  // out-of-window numbers, stray inits and spare packet types. Runs until the
  // session completes or 3000 packets have been sent.
  task automatic test_random_transfer();
    gbn_item_t pkt;
    int pick;
    int count;
    count = 0;
    while (rx_phase == PH_RUN && count < 3000) begin
      pkt  = random_packet();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pkt.op     = OP_DATA;
        pkt.seq_in = rx_expected[31:0];
      end else if (pick < 70) begin
        pkt.op     = OP_DATA;
        pkt.seq_in = rx_expected[31:0] - 32'($urandom_range(1, 8));
      end else if (pick < 76) begin
        pkt.op     = OP_DATA;
        pkt.seq_in = rx_expected[31:0] + 32'($urandom_range(1, 8));
      end else if (pick < 80) begin
        pkt.op = OP_DATA;                 // fully random number
      end else if (pick < 84) begin
        pkt.op     = OP_DATA;
        pkt.seq_in = {1'b1, rx_expected[30:0]};
      end else if (pick < 90) begin
        pkt.op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      end else begin
        pkt.op = OP_INIT;
        if ($urandom_range(0, 1)) pkt.peer_mode = rx_mode;
      end
      send_packet(pkt);
      count++;
    end
  endtask

  // Finish the file if the random part did not, then check that the
  // completed receiver drops every kind of packet.
  task automatic test_completion();
    gbn_item_t pkt;
    while (rx_phase == PH_RUN) begin
      pkt = random_packet();
      pkt.op     = OP_DATA;
      pkt.seq_in = rx_expected[31:0];
      send_packet(pkt);
    end
    pkt = random_packet();
    pkt.op     = OP_DATA;
    pkt.seq_in = rx_expected[31:0];
    send_packet(pkt);
    pkt.seq_in = rx_expected[31:0] - 32'd1;
    send_packet(pkt);
    pkt.op        = OP_INIT;
    pkt.peer_mode = rx_mode;
    send_packet(pkt);
    pkt.op = OP_SPARE_LO;
    send_packet(pkt);
    pkt.op = OP_SPARE_HI;
    send_packet(pkt);
  endtask

  // Output side stall: one draw per ack, with calm stretches of no stalling.
  initial begin : result_stall
    int hold;
    bit calm;
    calm = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Ack checker: every accepted ack against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (acks_due.size() == 0) begin
        $display("%0t: ack with none expected, got ack %0d deliver %0b status %0d",
                 $time, out_ack_number, out_deliver, out_status);
        mismatches++;
      end else begin
        ack_want = acks_due.pop_front();
        check_field("ack_number", ack_want.ack_number, out_ack_number);
        check_field("deliver",    ack_want.deliver,    out_deliver);
        check_field("out_low",    ack_want.out_low,    out_low);
        check_field("out_high",   ack_want.out_high,   out_high);
        check_field("status",     ack_want.status,     out_status);
      end
    end
  end

  // Watchdog: ends the run when no transaction completes on any port for too
  // long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("go_back_n_receiver_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_mode_register();
    test_ignored_before_init();
    test_init();
    test_data_cases();
    // the mode is only sampled at init, so rewriting it mid-session is harmless
    drain();
    write_mode(8'h00);
    write_mode(8'hFF);
    test_random_transfer();
    test_completion();
    drain();
    if (mismatches == 0) begin
      $display("go_back_n_receiver_unit regression: pass");
    end else begin
      $display("go_back_n_receiver_unit regression: fail");
    end
    $finish;
  end

endmodule
